@@ hw/rtl/gsu_pkg.sv @@
`timescale 1ns / 1ps

package gsu_pkg;

    // Register file geometry
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Generator word and sample formats
    localparam int GEN_W = 32;
    localparam int SAMPLE_W = 36;
    localparam int RES_W = 38;

    // Centre of the sum: 6.0 with 32 fraction bits
    localparam logic [RES_W-1:0] CENTRE_FIXED = RES_W'(64'd6 << 32);

    // Saturation bounds of the sample
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORTABLE_MODE = 3'd0,
        CFG_MULT_MAIN     = 3'd1,
        CFG_INCR_MAIN     = 3'd2,
        CFG_MULT_SECOND   = 3'd3,
        CFG_INCR_SECOND   = 3'd4,
        CFG_SEED_MAIN     = 3'd5,
        CFG_SEED_SECOND   = 3'd6,
        CFG_SEED_SKIP     = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [GEN_W-1:0] RST_MULT_MAIN   = 32'd1664525;
    localparam logic [GEN_W-1:0] RST_INCR_MAIN   = 32'd1013904223;
    localparam logic [GEN_W-1:0] RST_MULT_SECOND = 32'd69069;
    localparam logic [GEN_W-1:0] RST_INCR_SECOND = 32'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_FLUSH_A,
        ST_FLUSH_B,
        ST_FINISH
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

@@ hw/rtl/gsu_if.sv @@
`timescale 1ns / 1ps

// Request channel: one sample per request.
interface gsu_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// Result channel carrying the sample.
interface gsu_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [gsu_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// Configuration write channel.
interface gsu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gsu_pkg::CFG_IDX_W-1:0]   index;
    logic [gsu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/gaussian_sum_of_uniforms_rng_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Payload                     Handshake
// i_in      in         restart (1)                 valid / ready
// o_out     out        sample (36, signed, Q3.32)  valid / ready
// i_cfg     in         index (3), data (32)        valid / ready, always ready
//
// A request is taken only when the block is idle. It then runs one
// multiply-add step per draw for DRAWS_PER_SAMPLE draws, passes the two
// flush states and the finish state, and only then takes the next
// request. Reset restores the register defaults and clears the
// generators. A stalled result stays in the output register; a new
// request is taken meanwhile and waits only at its own end.

module gaussian_sum_of_uniforms_rng_top #(
    parameter int DRAWS_PER_SAMPLE = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gsu_in_if.sink     i_in,
    gsu_out_if.source  o_out,
    gsu_cfg_if.sink    i_cfg
);

    gsu_pkg::t_cmd    w_cmd;
    gsu_pkg::t_status w_status;

    // Sequencer
    gsu_ctrl #(
        .DRAWS_PER_SAMPLE (DRAWS_PER_SAMPLE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in.valid),
        .o_req_ready (i_in.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Generators, accumulator and output register
    gsu_datapath #(
        .DRAWS_PER_SAMPLE (DRAWS_PER_SAMPLE)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_in.restart),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule

@@ hw/rtl/gsu_ctrl.sv @@
`timescale 1ns / 1ps

module gsu_ctrl #(
    parameter int DRAWS_PER_SAMPLE = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  gsu_pkg::t_status i_status,
    output gsu_pkg::t_cmd    o_cmd
);

    localparam int CNT_W = $clog2(DRAWS_PER_SAMPLE + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DRAWS_PER_SAMPLE - 1);

    gsu_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // State and draw counter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsu_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            gsu_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = gsu_pkg::ST_DRAW;
                end
            end
            gsu_pkg::ST_DRAW: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = gsu_pkg::ST_FLUSH_A;
                end
            end
            // The last draw still moves through the draw and sum stages.
            gsu_pkg::ST_FLUSH_A: begin
                n_state = gsu_pkg::ST_FLUSH_B;
            end
            gsu_pkg::ST_FLUSH_B: begin
                n_state = gsu_pkg::ST_FINISH;
            end
            // Wait until the output register is free, then load the sample.
            gsu_pkg::ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = gsu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gsu_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/gsu_datapath.sv @@
`timescale 1ns / 1ps

module gsu_datapath #(
    parameter int DRAWS_PER_SAMPLE = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_restart,
    input  gsu_pkg::t_cmd     i_cmd,
    output gsu_pkg::t_status  o_status,
    gsu_cfg_if.sink           i_cfg,
    gsu_out_if.source         o_out
);

    localparam int GW = gsu_pkg::GEN_W;
    localparam int SUM_W = GW + $clog2(DRAWS_PER_SAMPLE);

    // Configuration registers
    logic          r_portable;
    logic [GW-1:0] r_mult_m, r_incr_m, r_mult_s, r_incr_s;
    logic [GW-1:0] r_seed_m, r_seed_s, r_seed_skip;

    // Generator state
    logic [GW-1:0] r_gen_m, r_gen_s, r_skip, r_skip_rel, r_raw_s;
    logic [GW-1:0] r_draw;
    logic          r_s1_vld, r_s2_vld;
    logic [SUM_W-1:0] r_sum;

    // Output register
    logic                         r_out_vld;
    logic [gsu_pkg::SAMPLE_W-1:0] r_sample;

    logic [GW-1:0] w_prod_m, w_prod_s, w_raw_s, w_next_s, w_next_m, w_diff;
    logic [GW-1:0] w_load_skip;
    logic          w_hit;
    logic [gsu_pkg::RES_W-1:0] w_sum_ext, w_res;
    logic [gsu_pkg::SAMPLE_W-1:0] n_sample;

    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_portable  <= 1'b0;
            r_mult_m    <= gsu_pkg::RST_MULT_MAIN;
            r_incr_m    <= gsu_pkg::RST_INCR_MAIN;
            r_mult_s    <= gsu_pkg::RST_MULT_SECOND;
            r_incr_s    <= gsu_pkg::RST_INCR_SECOND;
            r_seed_m    <= '0;
            r_seed_s    <= '0;
            r_seed_skip <= '0;
        end else if (i_cfg.valid) begin
            case (gsu_pkg::t_cfg_idx'(i_cfg.index))
                gsu_pkg::CFG_PORTABLE_MODE: r_portable  <= i_cfg.data[0];
                gsu_pkg::CFG_MULT_MAIN:     r_mult_m    <= i_cfg.data;
                gsu_pkg::CFG_INCR_MAIN:     r_incr_m    <= i_cfg.data;
                gsu_pkg::CFG_MULT_SECOND:   r_mult_s    <= i_cfg.data;
                gsu_pkg::CFG_INCR_SECOND:   r_incr_s    <= i_cfg.data;
                gsu_pkg::CFG_SEED_MAIN:     r_seed_m    <= i_cfg.data;
                gsu_pkg::CFG_SEED_SECOND:   r_seed_s    <= i_cfg.data;
                gsu_pkg::CFG_SEED_SKIP:     r_seed_skip <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // One multiply-add per generator per cycle. The skip test compares the
    // product against the mark less the increment, so the bump rides in as
    // the carry of the same adder.
    always_comb begin
        w_prod_m = r_gen_m * r_mult_m;
        w_prod_s = r_gen_s * r_mult_s;
        w_next_m = w_prod_m + r_incr_m;
        w_raw_s  = w_prod_s + r_incr_s;
        w_hit    = (w_prod_s == r_skip_rel);
        w_next_s = w_prod_s + r_incr_s + GW'(w_hit);
        w_load_skip = i_restart ? r_seed_skip : r_skip;
    end

    // Generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_m <= '0;
            r_gen_s <= '0;
            r_skip  <= '0;
        end else if (i_cmd.load) begin
            if (i_restart) begin
                r_gen_m <= r_seed_m;
                r_gen_s <= r_seed_s;
                r_skip  <= r_seed_skip;
            end
        end else if (i_cmd.step) begin
            r_gen_m <= w_next_m;
            if (r_portable) begin
                r_gen_s <= w_next_s;
                r_skip  <= r_skip + GW'(w_hit);
            end
        end
    end

    // Mark less the second increment, refreshed for every request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_skip_rel <= w_load_skip - r_incr_s;
        end else if (i_cmd.step && r_portable) begin
            r_skip_rel <= r_skip_rel + GW'(w_hit);
        end
    end

    // Draw and sum stages behind the generator step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.step;
            r_s2_vld <= r_s1_vld;
        end
    end

    assign w_diff = r_gen_m - r_raw_s;

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_raw_s <= w_raw_s;
        end
        if (r_s1_vld) begin
            r_draw <= r_portable ? {w_diff[GW-1:9], 1'b1, 8'b0} : r_gen_m;
        end
        if (i_cmd.load) begin
            r_sum <= '0;
        end else if (r_s2_vld) begin
            r_sum <= r_sum + SUM_W'(r_draw);
        end
    end

    // Centre, negate in portable mode, and saturate
    always_comb begin
        w_sum_ext = gsu_pkg::RES_W'(r_sum);
        w_res = r_portable ? (gsu_pkg::CENTRE_FIXED - w_sum_ext)
                           : (w_sum_ext - gsu_pkg::CENTRE_FIXED);
        if (w_res[gsu_pkg::RES_W-1:gsu_pkg::SAMPLE_W-1] == '0 ||
            w_res[gsu_pkg::RES_W-1:gsu_pkg::SAMPLE_W-1] == '1) begin
            n_sample = w_res[gsu_pkg::SAMPLE_W-1:0];
        end else if (w_res[gsu_pkg::RES_W-1]) begin
            n_sample = gsu_pkg::SAMPLE_MIN;
        end else begin
            n_sample = gsu_pkg::SAMPLE_MAX;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_sample <= n_sample;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.sample      = $signed(r_sample);
    assign o_status.out_busy = r_out_vld && !o_out.ready;

endmodule

@@ test/tb_gaussian_sum_of_uniforms_rng_top.sv @@
`timescale 1ns / 1ps

module tb_gaussian_sum_of_uniforms_rng_top;

    localparam int DRAWS = 12;
    localparam int RANDOM_ITEMS = 700;
    localparam int HANG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 40;

    // One full set of register values.
    typedef struct {
        logic                      portable;
        logic [gsu_pkg::GEN_W-1:0] mult_main;
        logic [gsu_pkg::GEN_W-1:0] incr_main;
        logic [gsu_pkg::GEN_W-1:0] mult_second;
        logic [gsu_pkg::GEN_W-1:0] incr_second;
        logic [gsu_pkg::GEN_W-1:0] seed_main;
        logic [gsu_pkg::GEN_W-1:0] seed_second;
        logic [gsu_pkg::GEN_W-1:0] seed_skip;
    } t_regs;

    logic clk;
    logic rst_n;

    gsu_in_if  in_if ();
    gsu_out_if out_if ();
    gsu_cfg_if cfg_if ();

    gaussian_sum_of_uniforms_rng_top #(
        .DRAWS_PER_SAMPLE(DRAWS)
    ) dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in(in_if),
        .o_out(out_if),
        .i_cfg(cfg_if)
    );

    // Register copies and generator state of the predictor.
    t_regs                     regs;
    logic [gsu_pkg::GEN_W-1:0] lcg_main;
    logic [gsu_pkg::GEN_W-1:0] lcg_second;
    logic [gsu_pkg::GEN_W-1:0] skip_mark;

    logic                         pending_restarts[$];
    logic [gsu_pkg::SAMPLE_W-1:0] expected_samples[$];
    logic [gsu_pkg::SAMPLE_W-1:0] want_sample;

    int  queued_cnt;
    int  accepted_cnt;
    int  errors;
    int  hang_cycles;
    int  in_gap;
    int  in_calm;
    int  out_stall;
    int  out_calm;
    bit  req_fired;
    bit  res_fired;

    always #5 clk = ~clk;

    // Gap lengths: mostly short, a few long, with occasional gap-free stretches.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Register values biased toward the edges of the 32-bit range.
    function automatic logic [gsu_pkg::GEN_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Computes the sample for one request and advances the generator state.
    function automatic logic [gsu_pkg::SAMPLE_W-1:0] predict_sample(input logic restart);
        longint                    total;
        longint                    centre;
        longint                    hi;
        longint                    lo;
        logic [gsu_pkg::GEN_W-1:0] spread;
        int                        k;
        if (restart) begin
            lcg_main = regs.seed_main;
            lcg_second = regs.seed_second;
            skip_mark = regs.seed_skip;
        end
        total = 0;
        centre = longint'(6) << 32;
        hi = (longint'(1) << (gsu_pkg::SAMPLE_W - 1)) - 1;
        lo = -(longint'(1) << (gsu_pkg::SAMPLE_W - 1));
        for (k = 0; k < DRAWS; k++) begin
            lcg_main = lcg_main * regs.mult_main + regs.incr_main;
            if (regs.portable) begin
                lcg_second = lcg_second * regs.mult_second + regs.incr_second;
                spread = lcg_main - lcg_second;
                // The sentinel point is stepped over by bumping both words.
                if (lcg_second == skip_mark) begin
                    lcg_second = lcg_second + 32'd1;
                    skip_mark = skip_mark + 32'd1;
                end
                spread = (spread >> 8) | 32'd1;
                total += longint'({24'd0, spread, 8'd0});
            end else begin
                total += longint'({32'd0, lcg_main});
            end
        end
        total = regs.portable ? centre - total : total - centre;
        if (total > hi) total = hi;
        if (total < lo) total = lo;
        return total[gsu_pkg::SAMPLE_W-1:0];
    endfunction

    // Builds a random register set; often aims the skip mark at a real draw.
    function automatic t_regs rand_regs();
        t_regs                     r;
        logic [gsu_pkg::GEN_W-1:0] walk;
        int                        steps;
        r.portable = 1'($urandom_range(0, 1));
        r.mult_main = rand_word();
        r.incr_main = rand_word();
        r.mult_second = ($urandom_range(0, 3) == 0) ? gsu_pkg::RST_MULT_SECOND
                                                    : rand_word();
        r.incr_second = rand_word();
        r.seed_main = rand_word();
        r.seed_second = rand_word();
        r.seed_skip = rand_word();
        if ($urandom_range(0, 1) == 1) begin
            walk = r.seed_second;
            steps = $urandom_range(1, DRAWS);
            repeat (steps) walk = walk * r.mult_second + r.incr_second;
            r.seed_skip = walk;
        end
        return r;
    endfunction

    // Waits until every request is taken and every sample has come back.
    task automatic drain();
        while (accepted_cnt != queued_cnt || expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input gsu_pkg::t_cfg_idx idx,
                             input logic [gsu_pkg::GEN_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        case (idx)
            gsu_pkg::CFG_PORTABLE_MODE: regs.portable = val[0];
            gsu_pkg::CFG_MULT_MAIN:     regs.mult_main = val;
            gsu_pkg::CFG_INCR_MAIN:     regs.incr_main = val;
            gsu_pkg::CFG_MULT_SECOND:   regs.mult_second = val;
            gsu_pkg::CFG_INCR_SECOND:   regs.incr_second = val;
            gsu_pkg::CFG_SEED_MAIN:     regs.seed_main = val;
            gsu_pkg::CFG_SEED_SECOND:   regs.seed_second = val;
            gsu_pkg::CFG_SEED_SKIP:     regs.seed_skip = val;
            default: ;
        endcase
    endtask

    // Loads a whole register set once the block has gone quiet.
    task automatic program_regs(input t_regs r);
        logic [gsu_pkg::GEN_W-1:0] mode_word;
        drain();
        mode_word = $urandom;
        mode_word[0] = r.portable;
        write_reg(gsu_pkg::CFG_PORTABLE_MODE, mode_word);
        write_reg(gsu_pkg::CFG_MULT_MAIN, r.mult_main);
        write_reg(gsu_pkg::CFG_INCR_MAIN, r.incr_main);
        write_reg(gsu_pkg::CFG_MULT_SECOND, r.mult_second);
        write_reg(gsu_pkg::CFG_INCR_SECOND, r.incr_second);
        write_reg(gsu_pkg::CFG_SEED_MAIN, r.seed_main);
        write_reg(gsu_pkg::CFG_SEED_SECOND, r.seed_second);
        write_reg(gsu_pkg::CFG_SEED_SKIP, r.seed_skip);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic push_request(input logic restart);
        pending_restarts.push_back(restart);
        queued_cnt++;
    endtask

    // Request driver: record the handshake on the rising edge.
    always @(posedge clk) begin
        if (rst_n && in_if.valid && in_if.ready) begin
            expected_samples.push_back(predict_sample(in_if.restart));
            accepted_cnt++;
            req_fired = 1'b1;
        end
    end

    // Request driver: present the next request on the falling edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || req_fired) begin
            req_fired = 1'b0;
            if (in_gap > 0) begin
                in_if.valid <= 1'b0;
                in_gap--;
            end else if (pending_restarts.size() != 0) begin
                in_if.valid <= 1'b1;
                in_if.restart <= pending_restarts.pop_front();
                in_gap = pick_gap(in_calm);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Sample monitor: compare each sample with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            res_fired = 1'b1;
            if (expected_samples.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected sample %0d", $signed(out_if.sample));
            end else begin
                want_sample = expected_samples.pop_front();
                if (out_if.sample !== want_sample) begin
                    errors++;
                    if (errors <= 10)
                        $display("sample mismatch: expected %0d (%h), got %0d (%h)",
                                 $signed(want_sample), want_sample,
                                 $signed(out_if.sample), out_if.sample);
                end
            end
        end
    end

    // Sample monitor: random back-pressure on the result channel.
    always @(negedge clk) begin
        if (res_fired) begin
            res_fired = 1'b0;
            out_stall = pick_gap(out_calm);
        end
        if (!rst_n || out_stall > 0) begin
            out_if.ready <= 1'b0;
            if (out_stall > 0) out_stall--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                    || (cfg_if.valid && cfg_if.ready))
                hang_cycles = 0;
            else
                hang_cycles++;
            if (hang_cycles >= HANG_LIMIT) begin
                $display("tb_gaussian_sum_of_uniforms_rng_top failed");
                $finish;
            end
        end
    end

    initial begin
        t_regs setting;
        int    drawn;
        int    batch;
        int    k;

        clk = 1'b0;
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.restart = 1'b0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = gsu_pkg::CFG_PORTABLE_MODE;
        cfg_if.data = '0;
        queued_cnt = 0;
        accepted_cnt = 0;
        errors = 0;
        hang_cycles = 0;
        in_gap = 0;
        in_calm = 0;
        out_stall = 0;
        out_calm = 0;
        req_fired = 1'b0;
        res_fired = 1'b0;

        // Reset values of the predictor.
        regs.portable = 1'b0;
        regs.mult_main = gsu_pkg::RST_MULT_MAIN;
        regs.incr_main = gsu_pkg::RST_INCR_MAIN;
        regs.mult_second = gsu_pkg::RST_MULT_SECOND;
        regs.incr_second = gsu_pkg::RST_INCR_SECOND;
        regs.seed_main = '0;
        regs.seed_second = '0;
        regs.seed_skip = '0;
        lcg_main = '0;
        lcg_second = '0;
        skip_mark = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Fast mode from the reset state, with and without a restart.
        push_request(1'b0);
        push_request(1'b0);
        push_request(1'b1);
        push_request(1'b0);

        // Portable mode on default generators; after the restart the skip mark hits the first draw.
        setting = regs;
        setting.portable = 1'b1;
        setting.seed_skip = 32'd3;
        program_regs(setting);
        push_request(1'b0);
        push_request(1'b1);
        push_request(1'b0);

        // Constant second generator sitting on the mark, wrapping at all ones.
        setting.mult_main = '1;
        setting.incr_main = '1;
        setting.mult_second = 32'd1;
        setting.incr_second = '0;
        setting.seed_main = '1;
        setting.seed_second = '1;
        setting.seed_skip = '1;
        program_regs(setting);
        push_request(1'b1);
        push_request(1'b0);

        // Fast mode, every draw zero: the most negative sample.
        setting.portable = 1'b0;
        setting.mult_main = '0;
        setting.incr_main = '0;
        program_regs(setting);
        push_request(1'b1);
        push_request(1'b0);

        // Fast mode, every draw all ones: the most positive sample.
        setting.mult_main = 32'd1;
        setting.seed_main = '1;
        program_regs(setting);
        push_request(1'b1);

        // Portable mode with equal generators: the difference is always zero.
        setting.portable = 1'b1;
        setting.mult_main = '0;
        setting.incr_main = 32'd5;
        setting.mult_second = '0;
        setting.incr_second = 32'd5;
        setting.seed_skip = '0;
        program_regs(setting);
        push_request(1'b1);
        push_request(1'b0);

        // Portable mode with the largest difference.
        setting.mult_main = 32'd1;
        setting.incr_main = '0;
        setting.seed_main = '1;
        setting.incr_second = '0;
        setting.seed_second = '0;
        setting.seed_skip = 32'd1;
        program_regs(setting);
        push_request(1'b1);

        // Random register sets, each followed by a batch of requests.
        drawn = 0;
        while (drawn < RANDOM_ITEMS) begin
            program_regs(rand_regs());
            batch = $urandom_range(15, 60);
            for (k = 0; k < batch; k++) begin
                if (k == 0)
                    push_request($urandom_range(0, 3) != 0);
                else
                    push_request($urandom_range(0, 5) == 0);
            end
            drawn += batch;
        end

        drain();
        if (errors == 0) begin
            $display("tb_gaussian_sum_of_uniforms_rng_top passed");
        end else begin
            $display("tb_gaussian_sum_of_uniforms_rng_top failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/gsu_pkg.sv
hw/rtl/gsu_if.sv
hw/rtl/gsu_ctrl.sv
hw/rtl/gsu_datapath.sv
hw/rtl/gaussian_sum_of_uniforms_rng_top.sv
test/tb_gaussian_sum_of_uniforms_rng_top.sv
